FILE: hw/rtl/pcicfg_pkg.sv
// ----------------------------------------------------------------------------
// pcicfg_pkg
// Shared types, offsets and helpers for the PCI type-0 configuration header.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

    // sizing constants
    localparam int unsigned IO_SPAN_BYTES = 44;
    localparam int unsigned HEADER_BYTES  = 64;

    // access commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // access sizes
    localparam logic [1:0] SIZE_BYTE    = 2'd0;
    localparam logic [1:0] SIZE_HALF    = 2'd1;
    localparam logic [1:0] SIZE_DWORD   = 2'd2;
    localparam logic [1:0] SIZE_INVALID = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ID        = 2'd0;
    localparam logic [1:0] CFG_CLASS     = 2'd1;
    localparam logic [1:0] CFG_SUBSYSTEM = 2'd2;
    localparam logic [1:0] CFG_INTERRUPT = 2'd3;

    localparam logic [31:0] INTERRUPT_RESET = 32'h0000_010e;

    // header dword offsets
    localparam logic [7:0] OFF_ID        = 8'h00;
    localparam logic [7:0] OFF_CMD_STAT  = 8'h04;
    localparam logic [7:0] OFF_CLASS     = 8'h08;
    localparam logic [7:0] OFF_HDR_TYPE  = 8'h0c;
    localparam logic [7:0] OFF_BAR0      = 8'h10;
    localparam logic [7:0] OFF_CARDBUS   = 8'h28;
    localparam logic [7:0] OFF_SUBSYSTEM = 8'h2c;
    localparam logic [7:0] OFF_INTERRUPT = 8'h3c;
    localparam logic [7:0] DWORD_ALIGN   = 8'hfc;

    // reserved bits plus unsupported command enables
    localparam logic [31:0] CMD_UNSUPPORTED = 32'h0000_fbfa;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    // bit length of the io span, capped at 31
    function automatic int unsigned span_bits(input int unsigned span);
        int unsigned v;
        int unsigned n;
        v = span;
        n = 0;
        for (int i = 0; i < 31; i++) begin
            if (v != 0) begin
                v = v >> 1;
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int unsigned  SPAN_BITS    = span_bits(IO_SPAN_BYTES);
    localparam logic [31:0]  SPAN_LOWMASK = 32'((64'd1 << SPAN_BITS) - 64'd1);
    localparam logic [31:0]  BAR_SIZE_MASK = (ALL_ONES ^ SPAN_LOWMASK) | 32'd1;

    // header limit, one bit wider than the offset so 256 fits
    localparam logic [8:0] HEADER_LIMIT = 9'(HEADER_BYTES);

    // access width mask
    function automatic logic [31:0] size_mask(input logic [1:0] sz);
        logic [31:0] m;
        unique case (sz)
            SIZE_BYTE: m = 32'h0000_00ff;
            SIZE_HALF: m = 32'h0000_ffff;
            default:   m = ALL_ONES;
        endcase
        return m;
    endfunction

    typedef struct packed {
        logic        command;
        logic [7:0]  offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
    } access_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        disconnect;
        logic        io_base_valid;
        logic [15:0] io_base;
    } result_t;

endpackage

FILE: hw/rtl/pcicfg_regs.sv
// ----------------------------------------------------------------------------
// pcicfg_regs
// Header register file: read mux, byte-merged writes, command and BAR0 actions.
// ----------------------------------------------------------------------------
module pcicfg_regs
    import pcicfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        fire,
    input  access_t     acc,
    output result_t     res
);

    logic [31:0] id_reg,        id_next;
    logic [31:0] class_reg,     class_next;
    logic [31:0] subsystem_reg, subsystem_next;
    logic [31:0] interrupt_reg, interrupt_next;
    logic [31:0] cmd_stat_reg,  cmd_stat_next;
    logic [31:0] hdr_type_reg,  hdr_type_next;
    logic [31:0] bar0_reg,      bar0_next;
    logic [31:0] cardbus_reg,   cardbus_next;

    logic [7:0]  dw_off;
    logic [31:0] mask;
    logic [31:0] dword;
    logic [31:0] old_val;
    logic [31:0] merged;
    logic        is_write;

    assign dw_off   = acc.offset & DWORD_ALIGN;
    assign mask     = size_mask(acc.access_size);
    assign is_write = fire && (acc.command == CMD_WRITE) && (acc.access_size != SIZE_INVALID);

    // header dword read mux
    always_comb
    begin
        unique case (dw_off)
            OFF_ID:        dword = id_reg;
            OFF_CMD_STAT:  dword = cmd_stat_reg;
            OFF_CLASS:     dword = class_reg;
            OFF_HDR_TYPE:  dword = hdr_type_reg;
            OFF_BAR0:      dword = bar0_reg;
            OFF_CARDBUS:   dword = cardbus_reg;
            OFF_SUBSYSTEM: dword = subsystem_reg;
            OFF_INTERRUPT: dword = interrupt_reg;
            default:       dword = 32'd0;
        endcase
    end

    // byte merge of write data into the addressed dword
    assign old_val = dword;
    assign merged  = (old_val & ~mask) | (acc.write_data & mask);

    // configuration writes
    always_comb
    begin
        id_next        = id_reg;
        class_next     = class_reg;
        subsystem_next = subsystem_reg;
        interrupt_next = interrupt_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ID:        id_next        = cfg_wdata;
                CFG_CLASS:     class_next     = cfg_wdata;
                CFG_SUBSYSTEM: subsystem_next = cfg_wdata;
                CFG_INTERRUPT: interrupt_next = cfg_wdata;
                default:       id_next        = id_reg;
            endcase
        end
    end

    // request processing and result
    always_comb
    begin
        cmd_stat_next     = cmd_stat_reg;
        hdr_type_next     = hdr_type_reg;
        bar0_next         = bar0_reg;
        cardbus_next      = cardbus_reg;
        res.read_data     = 32'd0;
        res.disconnect    = 1'b0;
        res.io_base_valid = 1'b0;
        res.io_base       = 16'd0;

        if (acc.command == CMD_READ)
        begin
            priority if (acc.access_size == SIZE_INVALID)
                res.read_data = ALL_ONES;
            else if ({1'b0, dw_off} >= HEADER_LIMIT)
                res.read_data = mask;
            else
                res.read_data = dword & mask;
        end

        if (is_write)
        begin
            unique case (dw_off)
                OFF_CMD_STAT:
                begin
                    res.disconnect = (merged[15:0] == 16'd0);
                    cmd_stat_next  = merged & ~CMD_UNSUPPORTED;
                end
                OFF_HDR_TYPE:
                    hdr_type_next = merged;
                OFF_BAR0:
                begin
                    priority if (merged == ALL_ONES)
                        bar0_next = BAR_SIZE_MASK;
                    else if (merged != 32'd0)
                    begin
                        bar0_next         = {merged[31:2], 2'b01};
                        res.io_base_valid = 1'b1;
                        res.io_base       = {merged[15:2], 2'b00};
                    end
                    else
                        bar0_next = merged;
                end
                OFF_CARDBUS:
                    cardbus_next = merged;
                default:
                    cardbus_next = cardbus_reg;
            endcase
        end
    end

    // register update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg        <= 32'd0;
            class_reg     <= 32'd0;
            subsystem_reg <= 32'd0;
            interrupt_reg <= INTERRUPT_RESET;
            cmd_stat_reg  <= 32'd0;
            hdr_type_reg  <= 32'd0;
            bar0_reg      <= 32'd0;
            cardbus_reg   <= 32'd0;
        end
        else
        begin
            id_reg        <= id_next;
            class_reg     <= class_next;
            subsystem_reg <= subsystem_next;
            interrupt_reg <= interrupt_next;
            cmd_stat_reg  <= cmd_stat_next;
            hdr_type_reg  <= hdr_type_next;
            bar0_reg      <= bar0_next;
            cardbus_reg   <= cardbus_next;
        end
    end

endmodule

FILE: hw/rtl/pci_config_space_with_bar_sizing.sv
// ----------------------------------------------------------------------------
// pci_config_space_with_bar_sizing
// PCI type-0 configuration header for an I/O device with BAR0 sizing.
// ----------------------------------------------------------------------------
// Pipeline: a request is accepted into the input register, then the result register.
// Throughput: one request per cycle while rsp_stall is low; header registers
// update as a request moves from the input register into the result register.
// Reset: rst_n clears pipeline valids and the header state; interrupt_word
// resets to 0x10E, the other read-only words to zero.
module pci_config_space_with_bar_sizing
    import pcicfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic        command,
    input  logic [7:0]  offset,
    input  logic [1:0]  access_size,
    input  logic [31:0] write_data,

    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] read_data,
    output logic        disconnect,
    output logic        io_base_valid,
    output logic [15:0] io_base,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic    in_vld_reg;
    access_t in_reg;
    logic    out_vld_reg;
    result_t out_reg;
    result_t res;
    logic    out_load;
    logic    move;
    logic    take;

    // flow control
    assign out_load  = !out_vld_reg || !rsp_stall;
    assign move      = in_vld_reg && out_load;
    assign req_stall = in_vld_reg && !out_load;
    assign take      = req_valid && !req_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (take)
            in_vld_reg <= 1'b1;
        else if (move)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= '{command: command, offset: offset,
                        access_size: access_size, write_data: write_data};
    end

    // header registers and access logic
    pcicfg_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fire      (move),
        .acc       (in_reg),
        .res       (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_load)
            out_vld_reg <= move;
    end

    always_ff @(posedge clk)
    begin
        if (move)
            out_reg <= res;
    end

    assign rsp_valid     = out_vld_reg;
    assign read_data     = out_reg.read_data;
    assign disconnect    = out_reg.disconnect;
    assign io_base_valid = out_reg.io_base_valid;
    assign io_base       = out_reg.io_base;

endmodule

FILE: test/tb_pci_config_space_with_bar_sizing.sv
// ----------------------------------------------------------------------------
// tb_pci_config_space_with_bar_sizing
// Self-checking bench for the type-0 configuration header with BAR0 sizing.
// A short table of directed requests covers reset values, reads beyond the
// header, the invalid width, command disconnects, BAR0 sizing and port base
// updates. Random requests follow across several read-only header settings.
// A shadow copy of the header predicts each response not typed by hand in
// the table; a monitor checks the responses in order. Random gaps and stalls
// on both sides.
module tb_pci_config_space_with_bar_sizing;
    import pcicfg_pkg::*;

    // BAR0 contents after an all-ones write: next power of two above the span
    localparam int          SPAN_WIDTH = $clog2(IO_SPAN_BYTES + 1);
    localparam logic [31:0] SIZED_BAR0 = ~((32'd1 << SPAN_WIDTH) - 32'd1) | 32'd1;

    typedef struct {
        access_t acc;
        bit      typed;
        result_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        command;
    logic [7:0]  offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [31:0] read_data;
    logic        disconnect;
    logic        io_base_valid;
    logic [15:0] io_base;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // shadow of the read-only words and the writable header dwords
    logic [31:0] shadow_id;
    logic [31:0] shadow_class;
    logic [31:0] shadow_subsystem;
    logic [31:0] shadow_interrupt;
    logic [31:0] shadow_cmd_status;
    logic [31:0] shadow_hdr_type;
    logic [31:0] shadow_bar0;
    logic [31:0] shadow_cardbus;

    result_t     pending_results[$];
    row_t        directed_rows[$];
    result_t     want;
    int unsigned mismatch_count = 0;
    bit          idle_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned stall_roll;

    pci_config_space_with_bar_sizing dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .command       (command),
        .offset        (offset),
        .access_size   (access_size),
        .write_data    (write_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .read_data     (read_data),
        .disconnect    (disconnect),
        .io_base_valid (io_base_valid),
        .io_base       (io_base),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // predict the response of one request and advance the shadow header
    function automatic result_t predict_access(input access_t a);
        result_t     r;
        logic [7:0]  dw;
        logic [31:0] m;
        logic [31:0] merged;
        r  = '0;
        dw = a.offset & DWORD_ALIGN;
        case (a.access_size)
            SIZE_BYTE: m = 32'h0000_00ff;
            SIZE_HALF: m = 32'h0000_ffff;
            default:   m = ALL_ONES;
        endcase
        if (a.command == CMD_READ)
        begin
            if (a.access_size == SIZE_INVALID)
                r.read_data = ALL_ONES;
            else if (dw >= HEADER_BYTES)
                r.read_data = m;
            else
            begin
                case (dw)
                    OFF_ID:        r.read_data = shadow_id & m;
                    OFF_CMD_STAT:  r.read_data = shadow_cmd_status & m;
                    OFF_CLASS:     r.read_data = shadow_class & m;
                    OFF_HDR_TYPE:  r.read_data = shadow_hdr_type & m;
                    OFF_BAR0:      r.read_data = shadow_bar0 & m;
                    OFF_CARDBUS:   r.read_data = shadow_cardbus & m;
                    OFF_SUBSYSTEM: r.read_data = shadow_subsystem & m;
                    OFF_INTERRUPT: r.read_data = shadow_interrupt & m;
                    default:       r.read_data = 32'd0;
                endcase
            end
        end
        else if (a.access_size != SIZE_INVALID)
        begin
            case (dw)
                OFF_CMD_STAT:
                begin
                    merged = (shadow_cmd_status & ~m) | (a.write_data & m);
                    r.disconnect = (merged[15:0] == 16'd0);
                    shadow_cmd_status = merged & ~CMD_UNSUPPORTED;
                end
                OFF_HDR_TYPE:
                    shadow_hdr_type = (shadow_hdr_type & ~m) | (a.write_data & m);
                OFF_BAR0:
                begin
                    merged = (shadow_bar0 & ~m) | (a.write_data & m);
                    if (merged == ALL_ONES)
                        shadow_bar0 = SIZED_BAR0;
                    else if (merged != 32'd0)
                    begin
                        shadow_bar0 = {merged[31:2], 2'b01};
                        r.io_base_valid = 1'b1;
                        r.io_base = {shadow_bar0[15:2], 2'b00};
                    end
                    else
                        shadow_bar0 = 32'd0;
                end
                OFF_CARDBUS:
                    shadow_cardbus = (shadow_cardbus & ~m) | (a.write_data & m);
                default: ;
            endcase
        end
        return r;
    endfunction

    // random request, weighted toward the writable dwords and BAR0 patterns
    function automatic access_t random_access();
        access_t     a;
        int unsigned pick;
        a.command = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 65)
        begin
            pick = $urandom_range(0, 11);
            case (pick)
                0:       a.offset = OFF_ID;
                1, 2:    a.offset = OFF_CMD_STAT;
                3:       a.offset = OFF_CLASS;
                4:       a.offset = OFF_HDR_TYPE;
                5, 6, 7: a.offset = OFF_BAR0;
                8:       a.offset = OFF_CARDBUS;
                9:       a.offset = OFF_SUBSYSTEM;
                10:      a.offset = OFF_INTERRUPT;
                default: a.offset = 8'($urandom_range(0, 15)) << 2;
            endcase
            a.offset[1:0] = 2'($urandom_range(0, 3));
        end
        else
            a.offset = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            a.access_size = SIZE_INVALID;
        else
            a.access_size = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0, 1:    a.write_data = ALL_ONES;
            2:       a.write_data = 32'd0;
            3:       a.write_data = {16'hffff, 16'($urandom_range(0, 65535))};
            4:       a.write_data = {16'($urandom_range(0, 65535)), 16'h0000};
            5:       a.write_data = 32'h0000_ffff;
            default: a.write_data = $urandom;
        endcase
        return a;
    endfunction

    // idle cycles between requests, mostly none, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // directed table entry; typed rows carry a response read off by hand
    task automatic add_row(input logic cmd, input logic [7:0] off, input logic [1:0] sz,
                           input logic [31:0] wd, input bit typed,
                           input logic [31:0] rd, input logic disc);
        row_t row;
        row.acc.command     = cmd;
        row.acc.offset      = off;
        row.acc.access_size = sz;
        row.acc.write_data  = wd;
        row.typed           = typed;
        row.res             = '0;
        row.res.read_data   = rd;
        row.res.disconnect  = disc;
        directed_rows.push_back(row);
    endtask

    // present one request and record its response once accepted
    task automatic send_request(input access_t a, input bit typed, input result_t typed_res);
        result_t predicted;
        @(negedge clk);
        req_valid   <= 1'b1;
        command     <= a.command;
        offset      <= a.offset;
        access_size <= a.access_size;
        write_data  <= a.write_data;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_access(a);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic hold_off(input int unsigned cycles);
        if (cycles != 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (cycles - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    // rewrite all four read-only words while the block is idle
    task automatic load_header_words(input logic [31:0] id_v, input logic [31:0] class_v,
                                     input logic [31:0] sub_v, input logic [31:0] intr_v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ID;
        cfg_wdata <= id_v;
        @(negedge clk);
        cfg_index <= CFG_CLASS;
        cfg_wdata <= class_v;
        @(negedge clk);
        cfg_index <= CFG_SUBSYSTEM;
        cfg_wdata <= sub_v;
        @(negedge clk);
        cfg_index <= CFG_INTERRUPT;
        cfg_wdata <= intr_v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_id        = id_v;
        shadow_class     = class_v;
        shadow_subsystem = sub_v;
        shadow_interrupt = intr_v;
    endtask

    // response stall pattern
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_roll = $urandom_range(0, 99);
            if (!idle_on || stall_roll < 65)
            begin
                rsp_stall  <= 1'b0;
                stall_left = $urandom_range(1, 6);
            end
            else if (stall_roll < 93)
            begin
                rsp_stall  <= 1'b1;
                stall_left = $urandom_range(1, 3);
            end
            else
            begin
                rsp_stall  <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
        else
            stall_left = stall_left - 1;
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected response read_data %h", $time, read_data);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, read_data);
                    mismatch_count++;
                end
                if (disconnect !== want.disconnect)
                begin
                    $display("%0t: disconnect expected %b actual %b",
                             $time, want.disconnect, disconnect);
                    mismatch_count++;
                end
                if (io_base_valid !== want.io_base_valid)
                begin
                    $display("%0t: io_base_valid expected %b actual %b",
                             $time, want.io_base_valid, io_base_valid);
                    mismatch_count++;
                end
                if (io_base !== want.io_base)
                begin
                    $display("%0t: io_base expected %h actual %h",
                             $time, want.io_base, io_base);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        command     = CMD_READ;
        offset      = 8'd0;
        access_size = SIZE_BYTE;
        write_data  = 32'd0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_ID;
        cfg_wdata   = 32'd0;

        shadow_id         = 32'd0;
        shadow_class      = 32'd0;
        shadow_subsystem  = 32'd0;
        shadow_interrupt  = INTERRUPT_RESET;
        shadow_cmd_status = 32'd0;
        shadow_hdr_type   = 32'd0;
        shadow_bar0       = 32'd0;
        shadow_cardbus    = 32'd0;

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values, reads beyond the header and the invalid width
        add_row(CMD_READ,  OFF_ID,        SIZE_DWORD,   32'd0,    1, 32'd0,         0);
        add_row(CMD_READ,  OFF_INTERRUPT, SIZE_DWORD,   ALL_ONES, 1, 32'h0000_010e, 0);
        add_row(CMD_READ,  8'h3e,         SIZE_HALF,    32'd0,    1, 32'h0000_010e, 0);
        add_row(CMD_READ,  8'hff,         SIZE_BYTE,    ALL_ONES, 1, 32'h0000_00ff, 0);
        add_row(CMD_READ,  8'h40,         SIZE_HALF,    32'd0,    1, 32'h0000_ffff, 0);
        add_row(CMD_READ,  8'h80,         SIZE_DWORD,   32'd0,    1, ALL_ONES,      0);
        add_row(CMD_READ,  OFF_ID,        SIZE_INVALID, 32'd0,    1, ALL_ONES,      0);
        add_row(CMD_WRITE, OFF_BAR0,      SIZE_INVALID, ALL_ONES, 1, 32'd0,         0);
        add_row(CMD_READ,  OFF_BAR0,      SIZE_DWORD,   32'd0,    1, 32'd0,         0);
        // command writes: zero disconnects, unsupported bits clear
        add_row(CMD_WRITE, OFF_CMD_STAT,  SIZE_DWORD,   32'd0,    1, 32'd0,         1);
        add_row(CMD_WRITE, OFF_CMD_STAT,  SIZE_DWORD,   ALL_ONES, 0, 32'd0,         0);
        add_row(CMD_READ,  OFF_CMD_STAT,  SIZE_DWORD,   32'd0,    0, 32'd0,         0);
        add_row(CMD_WRITE, OFF_CMD_STAT,  SIZE_BYTE,    32'd0,    0, 32'd0,         0);
        // BAR0 sizing, port base, partial write and zero write
        add_row(CMD_WRITE, OFF_BAR0,      SIZE_DWORD,   ALL_ONES, 1, 32'd0,         0);
        add_row(CMD_READ,  OFF_BAR0,      SIZE_DWORD,   32'd0,    0, 32'd0,         0);
        add_row(CMD_WRITE, OFF_BAR0,      SIZE_DWORD,   32'h0000_c003, 0, 32'd0,    0);
        add_row(CMD_WRITE, 8'h13,         SIZE_BYTE,    32'h0000_00ff, 0, 32'd0,    0);
        add_row(CMD_WRITE, OFF_BAR0,      SIZE_DWORD,   32'd0,    1, 32'd0,         0);
        // other writable dwords
        add_row(CMD_WRITE, OFF_HDR_TYPE,  SIZE_HALF,    32'hffff_1234, 0, 32'd0,    0);
        add_row(CMD_READ,  OFF_HDR_TYPE,  SIZE_DWORD,   32'd0,    0, 32'd0,         0);
        add_row(CMD_WRITE, OFF_CARDBUS,   SIZE_DWORD,   ALL_ONES, 0, 32'd0,         0);
        add_row(CMD_READ,  8'h2b,         SIZE_BYTE,    32'd0,    0, 32'd0,         0);
        // read-only and unimplemented dwords ignore writes
        add_row(CMD_WRITE, OFF_ID,        SIZE_DWORD,   ALL_ONES, 1, 32'd0,         0);
        add_row(CMD_WRITE, 8'h14,         SIZE_DWORD,   ALL_ONES, 1, 32'd0,         0);
        add_row(CMD_READ,  8'h14,         SIZE_DWORD,   32'd0,    1, 32'd0,         0);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].res);
            hold_off(pick_gap());
        end
        wait_for_results();

        // random phases over several header settings; one phase without idling
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       load_header_words(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
                1:       load_header_words(32'd0, 32'd0, 32'd0, 32'd0);
                default: load_header_words($urandom, $urandom, $urandom, $urandom);
            endcase
            idle_on = (phase != 1);
            repeat (300)
            begin
                send_request(random_access(), 1'b0, '0);
                hold_off(pick_gap());
            end
            wait_for_results();
        end

        idle_on = 1'b1;
        repeat (8)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/pcicfg_pkg.sv
hw/rtl/pcicfg_regs.sv
hw/rtl/pci_config_space_with_bar_sizing.sv
test/tb_pci_config_space_with_bar_sizing.sv
